>>> hdl/sba_pkg.sv
// Shared types, codes and constants of the sparse backprojection accumulator.
package sba_pkg;

    localparam int SBA_MAX_PIXELS = 65536;

    localparam int SBA_IDX_W  = 17;
    localparam int SBA_W_W    = 16;
    localparam int SBA_P_W    = 24;
    localparam int SBA_SUM_W  = 48;
    localparam int SBA_PROD_W = SBA_W_W + 1 + SBA_P_W;
    localparam int SBA_ST_W   = 2;

    localparam logic [SBA_IDX_W-1:0] SBA_PIXELS_RESET = 17'd65536;

    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [SBA_ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [SBA_ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [SBA_ST_W-1:0] ST_SAT   = 2'd2;

    typedef struct packed {
        logic                        cmd;
        logic [SBA_IDX_W-1:0]        pixel_index;
        logic [SBA_W_W-1:0]          weight;
        logic signed [SBA_P_W-1:0]   proj_value;
    } sba_in_t;

    typedef struct packed {
        logic [SBA_IDX_W-1:0]        out_index;
        logic signed [SBA_SUM_W-1:0] pixel_sum;
        logic [SBA_ST_W-1:0]         status;
    } sba_out_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_ADD,
        S_WRITE
    } sba_state_t;

    // controller -> datapath
    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic calc_en;
        logic wb_en;
        logic load_out;
    } sba_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
    } sba_stat_t;

endpackage

>>> hdl/sba_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module sba_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 65536,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/sba_ctrl.sv
// Controller: clearing sweep, per-item sequence and output register handshake.
module sba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  sba_pkg::sba_stat_t stat,
    output sba_pkg::sba_cmd_t  cmd
);
    import sba_pkg::*;

    sba_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.calc_en = 1'b1;
                state_next  = S_WRITE;
            end
            S_WRITE:
            begin
                // write-back repeats harmlessly while the result waits
                cmd.wb_en = 1'b1;
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    a_rise_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_WRITE))
        else $error("result appeared outside write-back");

    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_LOOKUP))
        else $error("accepted item did not start lookup");

    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) && stat.clear_last |=> (state_reg == S_IDLE))
        else $error("clearing sweep did not end");

    a_fell_taken: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(!out_stall))
        else $error("result dropped while stalled");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> out_free)
        else $error("output overwritten while held");

endmodule

>>> hdl/sba_datapath.sv
// Datapath: item and config registers, multiplier, saturating add, image store.
module sba_datapath #(
    parameter int MAX_PIXELS = sba_pkg::SBA_MAX_PIXELS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  sba_pkg::sba_in_t                        in_item,
    output sba_pkg::sba_out_t                       out_item,
    input  logic                                    cfg_valid,
    input  logic [sba_pkg::SBA_IDX_W-1:0]           cfg_data,
    input  sba_pkg::sba_cmd_t                       cmd,
    output sba_pkg::sba_stat_t                      stat
);
    import sba_pkg::*;

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    logic [SBA_IDX_W-1:0]        pixels_reg;
    logic [AW-1:0]               clr_cnt_reg;
    sba_in_t                     item_reg;
    logic signed [SBA_PROD_W-1:0] prod_reg;
    logic signed [SBA_SUM_W-1:0]  sum_reg;
    sba_out_t                    res_reg;
    sba_out_t                    out_reg;

    logic                        in_range;
    logic [31:0]                 idx_m1;
    logic [AW-1:0]               item_addr;
    logic [SBA_SUM_W-1:0]        rdata;
    logic signed [SBA_SUM_W-1:0] old_sum;
    logic signed [SBA_SUM_W:0]   acc;
    logic                        sat;
    logic signed [SBA_SUM_W-1:0] sat_sum;
    sba_out_t                    res_next;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [SBA_SUM_W-1:0]        ram_wdata;

    // config register and clearing counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixels_reg  <= SBA_PIXELS_RESET;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                pixels_reg <= cfg_data;
            end
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
        end
    end

    assign stat.clear_last = (clr_cnt_reg == AW'(MAX_PIXELS - 1));

    // range check against both the register and the store depth
    assign in_range = (item_reg.pixel_index != '0)
                   && (item_reg.pixel_index <= pixels_reg)
                   && (32'(item_reg.pixel_index) <= 32'(MAX_PIXELS));
    assign idx_m1    = 32'(item_reg.pixel_index) - 32'd1;
    assign item_addr = idx_m1[AW-1:0];

    assign old_sum = signed'(rdata);
    assign acc     = (SBA_SUM_W+1)'(old_sum) + (SBA_SUM_W+1)'(prod_reg);
    assign sat     = (acc[SBA_SUM_W] != acc[SBA_SUM_W-1]);

    always_comb
    begin
        if (!sat)
        begin
            sat_sum = acc[SBA_SUM_W-1:0];
        end
        else if (acc[SBA_SUM_W])
        begin
            sat_sum = {1'b1, {(SBA_SUM_W-1){1'b0}}};
        end
        else
        begin
            sat_sum = {1'b0, {(SBA_SUM_W-1){1'b1}}};
        end
    end

    always_comb
    begin
        res_next.out_index = item_reg.pixel_index;
        res_next.pixel_sum = '0;
        res_next.status    = ST_OK;
        if (!in_range)
        begin
            res_next.status = ST_RANGE;
        end
        else if (item_reg.cmd == CMD_READ)
        begin
            res_next.pixel_sum = old_sum;
        end
        else if (sat)
        begin
            res_next.status = ST_SAT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_item;
        end
        prod_reg <= signed'({1'b0, item_reg.weight}) * item_reg.proj_value;
        if (cmd.calc_en)
        begin
            sum_reg <= sat_sum;
            res_reg <= res_next;
        end
        if (cmd.load_out)
        begin
            out_reg <= res_reg;
        end
    end

    assign ram_we    = cmd.clear_step || (cmd.wb_en && in_range);
    assign ram_waddr = cmd.clear_step ? clr_cnt_reg : item_addr;
    assign ram_wdata = (cmd.clear_step || item_reg.cmd == CMD_READ) ? '0 : sum_reg;

    sba_ram #(
        .WIDTH (SBA_SUM_W),
        .DEPTH (MAX_PIXELS)
    ) u_image_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (item_addr),
        .rdata (rdata)
    );

    assign out_item = out_reg;

endmodule

>>> hdl/sparse_backprojection_accumulator.sv
// Sparse backprojection accumulator: top level joining controller and datapath.
// Each item passes through load, store read, multiply-add with saturation and
// write-back, as set by the single read/write port pair of the image store and
// the registered multiplier; a finished result sits in the output register
// while the next item is taken, and write-back waits only if that register is
// still held. After reset the block sweeps the image store to zero, one pixel a
// cycle, and stalls its input until done. The user must write pixels_in_use via
// cfg_valid only while no item is in flight; the block does not enforce this.
module sparse_backprojection_accumulator #(
    parameter int MAX_PIXELS = sba_pkg::SBA_MAX_PIXELS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  sba_pkg::sba_in_t              in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output sba_pkg::sba_out_t             out_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sba_pkg::SBA_IDX_W-1:0] cfg_data
);
    import sba_pkg::*;

    sba_cmd_t  cmd;
    sba_stat_t stat;

    assign cfg_ready = 1'b1;

    sba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    sba_datapath #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .out_item  (out_item),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the sparse backprojection accumulator.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sba_pkg::*;

    localparam int          HOLD_CYCLES = 300;
    localparam int          CYCLE_LIMIT = 500000;
    localparam int unsigned IDX_TOP     = (1 << SBA_IDX_W) - 1;
    localparam longint      SUM_HI      = (longint'(1) <<< (SBA_SUM_W - 1)) - 1;
    localparam longint      SUM_LO      = -SUM_HI - 1;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    sba_in_t              in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    sba_out_t             out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [SBA_IDX_W-1:0] cfg_data  = '0;

    // shadow copy of the image store and the pixel count register
    longint               img_sums [SBA_MAX_PIXELS];
    logic [SBA_IDX_W-1:0] pixels_cfg = SBA_PIXELS_RESET;
    sba_out_t             sum_q [$];

    int err_cnt  = 0;
    int cycles   = 0;
    bit idle_en  = 1'b1;
    bit hold_req = 1'b0;

    sparse_backprojection_accumulator #(
        .MAX_PIXELS(SBA_MAX_PIXELS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int unsigned pixel_limit();
        return (pixels_cfg > SBA_MAX_PIXELS) ? SBA_MAX_PIXELS : int'(pixels_cfg);
    endfunction

    // expected result of one item; updates the shadow store
    function automatic sba_out_t predict_pixel(input sba_in_t it);
        sba_out_t    r;
        int unsigned a;
        longint      s;
        r.out_index = it.pixel_index;
        r.pixel_sum = '0;
        r.status    = ST_OK;
        if (it.pixel_index == 0 || it.pixel_index > pixel_limit())
            r.status = ST_RANGE;
        else
        begin
            a = it.pixel_index - 1;
            if (it.cmd == CMD_ACCUM)
            begin
                s = img_sums[a]
                    + longint'({1'b0, it.weight}) * longint'($signed(it.proj_value));
                if (s > SUM_HI)
                begin
                    s        = SUM_HI;
                    r.status = ST_SAT;
                end
                else if (s < SUM_LO)
                begin
                    s        = SUM_LO;
                    r.status = ST_SAT;
                end
                img_sums[a] = s;
            end
            else
            begin
                r.pixel_sum = img_sums[a][SBA_SUM_W-1:0];
                img_sums[a] = 0;
            end
        end
        return r;
    endfunction

    function automatic sba_in_t mk_item(input logic cmd, input int unsigned idx,
                                        input logic [SBA_W_W-1:0] w,
                                        input logic signed [SBA_P_W-1:0] p);
        sba_in_t it;
        it.cmd         = cmd;
        it.pixel_index = SBA_IDX_W'(idx);
        it.weight      = w;
        it.proj_value  = p;
        return it;
    endfunction

    // indexes cluster at both ends of the pixels in use, with some strays
    function automatic sba_in_t rand_item(input int unsigned lim);
        sba_in_t     it;
        int unsigned low_hi;
        int unsigned top_lo;
        low_hi = (lim == 0) ? 1 : ((lim < 16) ? lim : 16);
        top_lo = (lim > 12) ? lim - 12 : 1;
        it.cmd = ($urandom_range(0, 99) < 25) ? CMD_READ : CMD_ACCUM;
        case ($urandom_range(0, 19))
            0, 1:    it.pixel_index = SBA_IDX_W'($urandom_range(0, IDX_TOP));
            2:       it.pixel_index = '0;
            3, 4, 5, 6, 7, 8, 9, 10:
                     it.pixel_index = SBA_IDX_W'($urandom_range(1, low_hi));
            default: it.pixel_index = SBA_IDX_W'($urandom_range(top_lo, lim + 2));
        endcase
        it.weight     = SBA_W_W'($urandom);
        it.proj_value = SBA_P_W'($urandom);
        return it;
    endfunction

    // called at a rising edge; returns at the edge that took the item
    task automatic send_item(input sba_in_t it);
        logic ok;
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
        begin
            @(negedge clk);
            ok = !in_stall;
            @(posedge clk);
        end
        while (!ok);
        sum_q.push_back(predict_pixel(it));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sum_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_pixels(input logic [SBA_IDX_W-1:0] v);
        logic ok;
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
        begin
            @(negedge clk);
            ok = cfg_ready;
            @(posedge clk);
        end
        while (!ok);
        cfg_valid  <= 1'b0;
        pixels_cfg = v;
    endtask

    task automatic test_basic();
        write_pixels(SBA_PIXELS_RESET);
        send_item(mk_item(CMD_ACCUM, 1, 16'hFFFF, 24'sh7FFFFF));
        send_item(mk_item(CMD_ACCUM, 1, 16'hFFFF, 24'sh800000));
        send_item(mk_item(CMD_READ, 1, 16'h0000, 24'sh000000));
        send_item(mk_item(CMD_READ, 1, 16'hFFFF, 24'sh7FFFFF));
        send_item(mk_item(CMD_ACCUM, SBA_MAX_PIXELS, 16'h0001, 24'shFFFFFF));
        send_item(mk_item(CMD_READ, SBA_MAX_PIXELS, 16'h0000, 24'sh000000));
        send_item(mk_item(CMD_ACCUM, 0, 16'h1234, 24'sh123456));
        send_item(mk_item(CMD_READ, 0, 16'h0000, 24'sh000000));
        send_item(mk_item(CMD_ACCUM, SBA_MAX_PIXELS + 1, 16'hFFFF, 24'sh7FFFFF));
        send_item(mk_item(CMD_READ, IDX_TOP, 16'hFFFF, 24'shFFFFFF));
        send_item(mk_item(CMD_ACCUM, 2, 16'h0000, 24'sh7FFFFF));
        send_item(mk_item(CMD_ACCUM, 3, 16'hFFFF, 24'sh000000));
        send_item(mk_item(CMD_READ, 2, 16'h0000, 24'sh000000));
        send_item(mk_item(CMD_READ, 3, 16'h0000, 24'sh000000));
        // same pixel back to back checks read after write-back
        send_item(mk_item(CMD_ACCUM, 5, 16'h8000, 24'sh400000));
        send_item(mk_item(CMD_ACCUM, 5, 16'h1001, 24'shC00001));
        send_item(mk_item(CMD_ACCUM, 5, 16'h7FFF, 24'sh0ABCDE));
        send_item(mk_item(CMD_READ, 5, 16'h0000, 24'sh000000));
        drain();
    endtask

    task automatic test_limits();
        write_pixels(SBA_IDX_W'(1));
        send_item(mk_item(CMD_ACCUM, 1, 16'h5555, 24'shAAAAAA));
        send_item(mk_item(CMD_ACCUM, 2, 16'hAAAA, 24'sh555555));
        send_item(mk_item(CMD_READ, 2, 16'h0000, 24'sh000000));
        send_item(mk_item(CMD_READ, 1, 16'h0000, 24'sh000000));
        drain();
        // zero pixels: nothing is in range
        write_pixels('0);
        send_item(mk_item(CMD_ACCUM, 1, 16'hFFFF, 24'sh7FFFFF));
        send_item(mk_item(CMD_READ, 1, 16'h0000, 24'sh000000));
        drain();
        // count above the store size is clipped
        write_pixels(SBA_IDX_W'(IDX_TOP));
        send_item(mk_item(CMD_ACCUM, SBA_MAX_PIXELS, 16'hFFFF, 24'sh800000));
        send_item(mk_item(CMD_READ, SBA_MAX_PIXELS + 1, 16'h0000, 24'sh000000));
        send_item(mk_item(CMD_READ, SBA_MAX_PIXELS, 16'h0000, 24'sh000000));
        drain();
    endtask

    // drive one pixel into the upper bound, clear it, then into the lower bound
    task automatic test_saturation();
        int unsigned pix;
        int          n;
        write_pixels(SBA_PIXELS_RESET);
        pix = $urandom_range(1, SBA_MAX_PIXELS);
        for (n = 0; n < 620; n++)
        begin
            if (n == 310)
                send_item(mk_item(CMD_READ, pix, 16'h0000, 24'sh000000));
            else if ($urandom_range(0, 9) == 0)
                send_item(rand_item(pixel_limit()));
            else if (n < 310)
                send_item(mk_item(CMD_ACCUM, pix, 16'($urandom_range(65000, 65535)),
                                  24'($urandom_range(8350000, 8388607))));
            else
                send_item(mk_item(CMD_ACCUM, pix, 16'($urandom_range(65000, 65535)),
                                  24'(-int'($urandom_range(8350000, 8388608)))));
        end
        send_item(mk_item(CMD_READ, pix, 16'h0000, 24'sh000000));
        drain();
    endtask

    task automatic test_random();
        logic [SBA_IDX_W-1:0] settings [4];
        int                   k;
        int                   n;
        settings[0] = SBA_IDX_W'($urandom_range(2, 200));
        settings[1] = SBA_IDX_W'(1);
        settings[2] = SBA_PIXELS_RESET;
        settings[3] = SBA_IDX_W'(IDX_TOP);
        for (k = 0; k < 4; k++)
        begin
            write_pixels(settings[k]);
            for (n = 0; n < 75; n++)
                send_item(rand_item(pixel_limit()));
            drain();
        end
    endtask

    // receiver holds off long enough for the block to fill up
    task automatic test_backpressure();
        int n;
        hold_req = 1'b1;
        for (n = 0; n < 40; n++)
            send_item(rand_item(8));
        drain();
    endtask

    task automatic test_quiet();
        int n;
        idle_en = 1'b0;
        write_pixels(SBA_IDX_W'($urandom_range(30, 60)));
        for (n = 0; n < 150; n++)
            send_item(rand_item(pixel_limit()));
        drain();
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // result checker: the item is taken at the next rising edge
    initial
    begin
        sba_out_t got;
        sba_out_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got = out_item;
                if (sum_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected item: index %0d sum %0d status %0d",
                                 got.out_index, got.pixel_sum, got.status);
                end
                else
                begin
                    want = sum_q.pop_front();
                    if (got.out_index !== want.out_index
                        || got.pixel_sum !== want.pixel_sum
                        || got.status !== want.status)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"mismatch: exp index %0d sum %0d status %0d, ",
                                      "got index %0d sum %0d status %0d"},
                                     want.out_index, want.pixel_sum, want.status,
                                     got.out_index, got.pixel_sum, got.status);
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic();
        test_limits();
        test_saturation();
        test_random();
        test_backpressure();
        test_quiet();
        repeat (20) @(posedge clk);
        if (err_cnt == 0 && sum_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sparse_backprojection_accumulator.f
hdl/sba_pkg.sv
hdl/sba_ram.sv
hdl/sba_ctrl.sv
hdl/sba_datapath.sv
hdl/sparse_backprojection_accumulator.sv
sim/tb_top.sv
